// File: design/csu_pkg.sv
package csu_pkg;

    // sizing of the semaphore table and of the per-semaphore wait queues
    localparam int NUM_SEMAPHORES  = 16;
    localparam int QUEUE_DEPTH     = 16;
    localparam int PROCESS_ID_BITS = 8;

    // signed count range
    localparam int CNT_W = 16;
    localparam logic signed [CNT_W-1:0] CNT_MAX = 16'sh7fff;
    localparam logic signed [CNT_W-1:0] CNT_MIN = 16'sh8000;

    typedef enum logic [1:0] {
        OP_INIT    = 2'd0,
        OP_WAIT    = 2'd1,
        OP_POST    = 2'd2,
        OP_DESTROY = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BLOCKED    = 3'd1,
        ST_NOT_FOUND  = 3'd2,
        ST_QUEUE_FULL = 3'd3,
        ST_OVERFLOW   = 3'd4
    } t_status;

    typedef struct packed {
        t_opcode     opcode;
        logic [3:0]  sem_id;
        logic [14:0] init_value;
        logic [7:0]  process_id;
    } t_req;

    typedef struct packed {
        t_status    status;
        logic       wake_valid;
        logic [7:0] wake_process_id;
        logic [3:0] sem_id_out;
    } t_rsp;

endpackage

// File: design/counting_semaphore_unit.sv
// Counting semaphore unit: a table of counting semaphores, each with its own FIFO of blocked
// process ids. Every request transaction (init, wait, post, destroy) yields exactly one
// response transaction carrying a status, an optional woken process id and the echoed
// semaphore id. The accept cycle launches the synchronous reads of the count memory and of the
// wait-queue memory (at the queue head); the execute state that follows modifies, writes back
// and loads the output register. Execute waits while a previous response is still held
// downstream, and no new request is accepted until execute completes. No clearing pass is
// needed after reset: only the valid bits are cleared, counts and queues are written by init
// and wait.
module counting_semaphore_unit
    import csu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    // request channel
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_req i_in_data,
    // response channel
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_rsp o_out_data
);

    // derived widths
    localparam int SW   = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
    localparam int HW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW   = $clog2(QUEUE_DEPTH + 1);
    localparam int SUMW = FW + 1;
    localparam int QN   = NUM_SEMAPHORES * QUEUE_DEPTH;
    localparam int QAW  = (QN > 1) ? $clog2(QN) : 1;
    localparam int PW   = PROCESS_ID_BITS;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;

    // per-semaphore state: count in a memory, valid/head/fill in flops
    logic signed [CNT_W-1:0] cnt_mem [NUM_SEMAPHORES];
    logic [PW-1:0]           q_mem   [QN];
    logic [NUM_SEMAPHORES-1:0] r_valid;
    logic [HW-1:0]           r_head [NUM_SEMAPHORES];
    logic [FW-1:0]           r_fill [NUM_SEMAPHORES];

    // request held for the execute cycle, plus registered memory read data
    t_req                    r_req;
    logic signed [CNT_W-1:0] r_cnt_rd;
    logic [PW-1:0]           r_q_rd;

    // output register
    logic r_out_valid;
    t_rsp r_out;
    t_rsp n_rsp;

    logic in_acc;
    logic out_take;
    logic exec_go;

    // write-back controls from the execute cycle
    logic                    cnt_we;
    logic signed [CNT_W-1:0] cnt_wdata;
    logic                    q_we;
    logic [QAW-1:0]          q_waddr;
    logic                    hf_we;
    logic [HW-1:0]           head_wdata;
    logic [FW-1:0]           fill_wdata;
    logic                    vld_set;
    logic                    vld_clr;

    logic [SW-1:0]   in_idx;
    logic [SW-1:0]   ex_idx;
    logic            ex_in_range;
    logic            ex_valid;
    logic [HW-1:0]   ex_head;
    logic [FW-1:0]   ex_fill;
    logic [SUMW-1:0] pos_sum;
    logic [HW-1:0]   tail_pos;
    logic [SUMW-1:0] head_inc;
    logic [HW-1:0]   head_next;
    logic [QAW-1:0]  q_raddr;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_take = r_out_valid && !i_out_stall;
    // execute may finish only when the output register is free or emptying
    assign exec_go  = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign in_idx = SW'(i_in_data.sem_id);
    assign ex_idx = SW'(r_req.sem_id);

    // queue slot at the head of the addressed semaphore, read at accept
    assign q_raddr = QAW'(QAW'(in_idx) * QAW'(QUEUE_DEPTH) + QAW'(r_head[in_idx]));

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req    <= i_in_data;
            r_cnt_rd <= cnt_mem[in_idx];
            r_q_rd   <= q_mem[q_raddr];
        end
    end

    // ---- execute: read-modify-write of one semaphore ----
    assign ex_in_range = (32'(r_req.sem_id) < NUM_SEMAPHORES);
    assign ex_valid    = ex_in_range && r_valid[ex_idx];
    assign ex_head     = r_head[ex_idx];
    assign ex_fill     = r_fill[ex_idx];

    // tail position, wrapped to the queue depth
    always_comb begin
        pos_sum = SUMW'(ex_head) + SUMW'(ex_fill);
        if (pos_sum >= SUMW'(QUEUE_DEPTH)) begin
            pos_sum = pos_sum - SUMW'(QUEUE_DEPTH);
        end
        tail_pos = HW'(pos_sum);
    end

    // head advance on a pop, wrapped
    always_comb begin
        head_inc = SUMW'(ex_head) + SUMW'(1);
        if (head_inc >= SUMW'(QUEUE_DEPTH)) begin
            head_next = '0;
        end else begin
            head_next = HW'(head_inc);
        end
    end

    assign q_waddr = QAW'(QAW'(ex_idx) * QAW'(QUEUE_DEPTH) + QAW'(tail_pos));

    always_comb begin
        n_rsp.status          = ST_OK;
        n_rsp.wake_valid      = 1'b0;
        n_rsp.wake_process_id = '0;
        n_rsp.sem_id_out      = r_req.sem_id;
        cnt_we     = 1'b0;
        cnt_wdata  = r_cnt_rd;
        q_we       = 1'b0;
        hf_we      = 1'b0;
        head_wdata = ex_head;
        fill_wdata = ex_fill;
        vld_set    = 1'b0;
        vld_clr    = 1'b0;
        if (!ex_in_range) begin
            n_rsp.status = ST_NOT_FOUND;
        end else if (r_req.opcode == OP_INIT) begin
            // create only when absent
            if (!ex_valid) begin
                vld_set    = 1'b1;
                cnt_we     = 1'b1;
                cnt_wdata  = CNT_W'(r_req.init_value);
                hf_we      = 1'b1;
                head_wdata = '0;
                fill_wdata = '0;
            end
        end else if (!ex_valid) begin
            n_rsp.status = ST_NOT_FOUND;
        end else begin
            unique case (r_req.opcode)
                OP_WAIT: begin
                    if (r_cnt_rd == CNT_MIN) begin
                        n_rsp.status = ST_OVERFLOW;
                    end else if (r_cnt_rd <= 0) begin
                        // caller blocks: needs a free queue slot
                        if (ex_fill >= FW'(QUEUE_DEPTH)) begin
                            n_rsp.status = ST_QUEUE_FULL;
                        end else begin
                            n_rsp.status = ST_BLOCKED;
                            q_we       = 1'b1;
                            hf_we      = 1'b1;
                            fill_wdata = ex_fill + FW'(1);
                            cnt_we     = 1'b1;
                            cnt_wdata  = r_cnt_rd - 16'sd1;
                        end
                    end else begin
                        cnt_we    = 1'b1;
                        cnt_wdata = r_cnt_rd - 16'sd1;
                    end
                end
                OP_POST: begin
                    if (r_cnt_rd == CNT_MAX) begin
                        n_rsp.status = ST_OVERFLOW;
                    end else begin
                        cnt_we    = 1'b1;
                        cnt_wdata = r_cnt_rd + 16'sd1;
                        // new count at or below zero with a waiter: wake the oldest
                        if ((r_cnt_rd < 0) && (ex_fill != '0)) begin
                            n_rsp.wake_valid      = 1'b1;
                            n_rsp.wake_process_id = 8'(r_q_rd);
                            hf_we      = 1'b1;
                            head_wdata = head_next;
                            fill_wdata = ex_fill - FW'(1);
                        end
                    end
                end
                OP_DESTROY: begin
                    vld_clr    = 1'b1;
                    hf_we      = 1'b1;
                    head_wdata = '0;
                    fill_wdata = '0;
                end
                default: begin
                    // init handled above
                end
            endcase
        end
    end

    // ---- memories ----
    always_ff @(posedge i_clk) begin
        if (exec_go && cnt_we) begin
            cnt_mem[ex_idx] <= cnt_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_go && q_we) begin
            q_mem[q_waddr] <= PW'(r_req.process_id);
        end
    end

    // head and fill, only meaningful for valid entries
    always_ff @(posedge i_clk) begin
        if (exec_go && hf_we) begin
            r_head[ex_idx] <= head_wdata;
            r_fill[ex_idx] <= fill_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (exec_go) begin
            if (vld_set) begin
                r_valid[ex_idx] <= 1'b1;
            end else if (vld_clr) begin
                r_valid[ex_idx] <= 1'b0;
            end
        end
    end

    // ---- control ----
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (exec_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (exec_go) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_go) begin
            r_out <= n_rsp;
        end
    end

    // ---- assertions ----
    // a new response only comes out of an execute cycle
    a_out_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_EXEC))
        else $error("response appeared without an execute cycle");

    // an accepted request enters the execute state next cycle
    a_acc_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_EXEC))
        else $error("accepted request did not enter execute");

    // a valid semaphore never holds more waiters than the queue depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EXEC) && ex_valid) |-> (ex_fill <= FW'(QUEUE_DEPTH)))
        else $error("wait queue fill beyond depth");

    // a wake is only reported with an ok status
    a_wake_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.wake_valid) |-> (o_out_data.status == ST_OK))
        else $error("wake reported with a non-ok status");

endmodule
